@@ hdl/mccq_pkg.sv @@
`timescale 1ns / 1ps

package mccq_pkg;

  localparam int unsigned NUM_BUTTONS_DEF = 2;

  localparam int unsigned POS_W   = 12;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned IVL_W   = 16;
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [SIZE_W-1:0] SCREEN_W_RST = 13'd640;
  localparam logic [SIZE_W-1:0] SCREEN_H_RST = 13'd480;
  localparam logic [IVL_W-1:0]  DBL_IVL_RST  = 16'd500;
  localparam logic              SWAP_RST     = 1'b0;

  typedef enum logic [2:0] {
    ST_NONE = 3'd0,
    ST_DOWN = 3'd1,
    ST_HELD = 3'd2,
    ST_UP   = 3'd3,
    ST_DBL  = 3'd4
  } btn_state_e;

  typedef enum logic [1:0] {
    REG_SCREEN_W = 2'd0,
    REG_SCREEN_H = 2'd1,
    REG_DBL_IVL  = 2'd2,
    REG_SWAP     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [SIZE_W-1:0] screen_width;
    logic [SIZE_W-1:0] screen_height;
    logic [IVL_W-1:0]  dbl_interval;
    logic              swap_buttons;
  } cfg_t;

endpackage

@@ hdl/mccq_regs.sv @@
`timescale 1ns / 1ps

module mccq_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mccq_pkg::PADDR_W-1:0]  paddr,
  input  logic [mccq_pkg::PDATA_W-1:0]  pwdata,
  output logic [mccq_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output mccq_pkg::cfg_t                cfg_o
);
  import mccq_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e idx;
  logic     wr_en;

  assign idx    = cfg_reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SCREEN_W: cfg_d.screen_width  = pwdata[SIZE_W-1:0];
        REG_SCREEN_H: cfg_d.screen_height = pwdata[SIZE_W-1:0];
        REG_DBL_IVL:  cfg_d.dbl_interval  = pwdata[IVL_W-1:0];
        REG_SWAP:     cfg_d.swap_buttons  = pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SCREEN_W: prdata = PDATA_W'(cfg_q.screen_width);
      REG_SCREEN_H: prdata = PDATA_W'(cfg_q.screen_height);
      REG_DBL_IVL:  prdata = PDATA_W'(cfg_q.dbl_interval);
      REG_SWAP:     prdata = PDATA_W'(cfg_q.swap_buttons);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= SCREEN_W_RST;
      cfg_q.screen_height <= SCREEN_H_RST;
      cfg_q.dbl_interval  <= DBL_IVL_RST;
      cfg_q.swap_buttons  <= SWAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ hdl/mccq_button.sv @@
`timescale 1ns / 1ps

module mccq_button (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         report_valid_i,
  input  logic                         level_i,
  input  logic                         moved_i,
  input  logic [mccq_pkg::TIME_W-1:0]  now_i,
  input  logic [mccq_pkg::IVL_W-1:0]   interval_i,
  output mccq_pkg::btn_state_e         state_o
);
  import mccq_pkg::*;

  logic              prev_q;
  logic [TIME_W-1:0] mark_q, mark_d;
  logic [TIME_W-1:0] iv;
  logic [TIME_W-1:0] mark_eff;
  logic              cur;
  logic              early;

  assign iv  = TIME_W'(interval_i);
  assign cur = report_valid_i ? level_i : prev_q;

  // movement pushes the mark back so the next press is a fresh one
  assign mark_eff = moved_i ? (now_i - iv) : mark_q;
  assign early    = now_i < (mark_eff + iv);

  always_comb begin
    mark_d  = mark_eff;
    state_o = ST_NONE;
    if (!cur) begin
      state_o = prev_q ? ST_UP : ST_NONE;
    end else if (prev_q) begin
      state_o = ST_HELD;
    end else if (!early) begin
      state_o = ST_DOWN;
      mark_d  = now_i;
    end else begin
      state_o = ST_DBL;
      mark_d  = now_i - iv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      mark_q <= '0;
    end else if (adv_i) begin
      prev_q <= cur;
      mark_q <= mark_d;
    end
  end

endmodule

@@ hdl/mouse_cursor_and_click_qualifier_top.sv @@
`timescale 1ns / 1ps
// An accepted word passes the input register, then the result register; the button and
// cursor state update as the result register loads. Throughput: one word per cycle
// unless out_stall_i stalls; the input register refills in the same cycle it drains.
// Reset (rst_ni low, asynchronous): cursor at 0,0, both buttons released, press marks 0,
// registers at 640 x 480, 500 ms interval, no swap; both pipeline stages empty.
module mouse_cursor_and_click_qualifier_top
  import mccq_pkg::*;
#(
  parameter int unsigned NumButtons = NUM_BUTTONS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          report_valid_i,
  input  logic signed [DELTA_W-1:0]     move_x_i,
  input  logic signed [DELTA_W-1:0]     move_y_i,
  input  logic signed [DELTA_W-1:0]     wheel_move_i,
  input  logic                          button0_level_i,
  input  logic                          button1_level_i,
  input  logic [TIME_W-1:0]             now_ms_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [POS_W-1:0]              cursor_x_o,
  output logic [POS_W-1:0]              cursor_y_o,
  output logic signed [DELTA_W-1:0]     delta_x_o,
  output logic signed [DELTA_W-1:0]     delta_y_o,
  output logic signed [DELTA_W-1:0]     wheel_o,
  output logic [2:0]                    left_state_o,
  output logic [2:0]                    right_state_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready
);

  cfg_t cfg;

  mccq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Clamp one axis: a size of 0 acts as 1 and anything above 4096 as 4096.
  function automatic logic [POS_W-1:0] clamp_axis(
    input logic [POS_W-1:0]          pos,
    input logic signed [DELTA_W-1:0] d,
    input logic [SIZE_W-1:0]         size
  );
    logic [SIZE_W-1:0]   eff;
    logic signed [17:0]  lim;
    logic signed [17:0]  p;
    eff = size;
    if (size == '0) begin
      eff = SIZE_W'(1);
    end else if (size > SIZE_W'(4096)) begin
      eff = SIZE_W'(4096);
    end
    lim = $signed(18'(eff)) - 18'sd1;
    p   = $signed(18'(pos)) + 18'(d);
    if (p < 18'sd0) begin
      return '0;
    end else if (p > lim) begin
      return lim[POS_W-1:0];
    end else begin
      return p[POS_W-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake. The input register takes a word whenever it is empty or drains
  // this cycle; it drains whenever the result register is empty or being read.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic in_accept;
  logic s1_adv;

  assign s1_adv     = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: hold the accepted word's fields.
  // ---------------------------------------------------------------------------
  logic                      s1_report_valid_q;
  logic signed [DELTA_W-1:0] s1_move_x_q, s1_move_y_q, s1_wheel_q;
  logic                      s1_btn0_q, s1_btn1_q;
  logic [TIME_W-1:0]         s1_now_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_report_valid_q <= report_valid_i;
      s1_move_x_q       <= move_x_i;
      s1_move_y_q       <= move_y_i;
      s1_wheel_q        <= wheel_move_i;
      s1_btn0_q         <= button0_level_i;
      s1_btn1_q         <= button1_level_i;
      s1_now_q          <= now_ms_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Single pass: gate deltas on the report flag, move and clamp the cursor.
  // ---------------------------------------------------------------------------
  logic signed [DELTA_W-1:0] dx, dy, dw;
  logic                      moved;
  logic [POS_W-1:0]          pos_x_q, pos_y_q, pos_x_d, pos_y_d;

  assign dx      = s1_report_valid_q ? s1_move_x_q : '0;
  assign dy      = s1_report_valid_q ? s1_move_y_q : '0;
  assign dw      = s1_report_valid_q ? s1_wheel_q  : '0;
  assign moved   = (dx != '0) || (dy != '0);
  assign pos_x_d = clamp_axis(pos_x_q, dx, cfg.screen_width);
  assign pos_y_d = clamp_axis(pos_y_q, dy, cfg.screen_height);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else if (s1_adv) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-button click qualifiers. Buttons past the two physical inputs read
  // released; a missing second button reports none.
  // ---------------------------------------------------------------------------
  btn_state_e st [NumButtons];
  btn_state_e st0, st1;

  for (genvar b = 0; b < NumButtons; b++) begin : g_btn
    logic lvl;
    if (b == 0) begin : g_b0
      assign lvl = s1_btn0_q;
    end else if (b == 1) begin : g_b1
      assign lvl = s1_btn1_q;
    end else begin : g_bx
      assign lvl = 1'b0;
    end

    mccq_button u_btn (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .adv_i          (s1_adv),
      .report_valid_i (s1_report_valid_q),
      .level_i        (lvl),
      .moved_i        (moved),
      .now_i          (s1_now_q),
      .interval_i     (cfg.dbl_interval),
      .state_o        (st[b])
    );
  end

  assign st0 = st[0];
  if (NumButtons > 1) begin : g_st1
    assign st1 = st[1];
  end else begin : g_st1_none
    assign st1 = ST_NONE;
  end

  // ---------------------------------------------------------------------------
  // Result register: advance whenever the input register drains.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]          cursor_x_q, cursor_y_q;
  logic signed [DELTA_W-1:0] delta_x_q, delta_y_q, wheel_q;
  btn_state_e                left_q, right_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      cursor_x_q <= pos_x_d;
      cursor_y_q <= pos_y_d;
      delta_x_q  <= dx;
      delta_y_q  <= dy;
      wheel_q    <= dw;
      left_q     <= cfg.swap_buttons ? st1 : st0;
      right_q    <= cfg.swap_buttons ? st0 : st1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cursor_x_o    = cursor_x_q;
  assign cursor_y_o    = cursor_y_q;
  assign delta_x_o     = delta_x_q;
  assign delta_y_o     = delta_y_q;
  assign wheel_o       = wheel_q;
  assign left_state_o  = left_q;
  assign right_state_o = right_q;

endmodule

@@ hdl/mccq_checker.sv @@
`timescale 1ns / 1ps

module mccq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [mccq_pkg::POS_W-1:0]          cursor_x_o,
  input logic signed [mccq_pkg::DELTA_W-1:0] delta_x_o,
  input logic [2:0]                          left_state_o,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite
);
  import mccq_pkg::*;

  logic             out_acc;
  logic             cfg_wr;
  logic             known_q;
  logic             left_pressed_q;
  logic [POS_W-1:0] last_x_q;

  assign out_acc = out_valid_o && !out_stall_i;
  assign cfg_wr  = psel && penable && pwrite;

  // track the last delivered word; drop the history on any register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q        <= 1'b0;
      left_pressed_q <= 1'b0;
      last_x_q       <= '0;
    end else if (cfg_wr) begin
      known_q <= 1'b0;
    end else if (out_acc) begin
      known_q        <= 1'b1;
      last_x_q       <= cursor_x_o;
      left_pressed_q <= (left_state_o == ST_DOWN) || (left_state_o == ST_HELD) ||
                        (left_state_o == ST_DBL);
    end
  end

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_state_o) && $stable(cursor_x_o))
    else $error("stalled result word changed");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty result register");

  a_pressed_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && known_q && left_pressed_q |->
      (left_state_o == ST_HELD) || (left_state_o == ST_UP))
    else $error("left button left the pressed state without an up");

  a_released_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && known_q && !left_pressed_q |->
      (left_state_o == ST_NONE) || (left_state_o == ST_DOWN) || (left_state_o == ST_DBL))
    else $error("left button held or up without a press");

  a_cursor_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && known_q && (delta_x_o == '0) |-> cursor_x_o == last_x_q)
    else $error("cursor x moved without a horizontal delta");

endmodule

bind mouse_cursor_and_click_qualifier_top mccq_checker u_mccq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .cursor_x_o   (cursor_x_o),
  .delta_x_o    (delta_x_o),
  .left_state_o (left_state_o),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite)
);
